// ===== src/lowercase_murmur2_token_hash_macros.svh =====
// Assertion helpers shared by the hash block. Each macro expects clk and rst_n in scope.
`ifndef LOWERCASE_MURMUR2_TOKEN_HASH_MACROS_SVH
`define LOWERCASE_MURMUR2_TOKEN_HASH_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define M2H_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define M2H_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/m2h_pkg.sv =====
package m2h_pkg;

    localparam logic [31:0] MUR_M      = 32'h5bd1e995;
    localparam logic [31:0] SEED_RESET = 32'h31415926;
    localparam int          QDEPTH     = 2;
    localparam int          KSHIFT     = 24;
    localparam int          FSHIFT_A   = 13;
    localparam int          FSHIFT_B   = 15;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] seed_len;
        logic       is_first;
        logic       is_last;
        logic       take_en;
    } m2h_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_MIXH,
        ST_FIN_TAIL,
        ST_FIN_AVAL,
        ST_EMIT
    } m2h_state_t;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        begin
            r = b;
            if (b inside {[8'h41 : 8'h5A]})
            begin
                r = b + 8'h20;
            end
            return r;
        end
    endfunction

endpackage

// ===== src/m2h_front.sv =====
module m2h_front
    import m2h_pkg::*;
#(
    parameter int MAX_LEN = 31
)
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic [4:0] string_length,
    input  logic       first_item,
    input  logic       last_item,
    input  logic       q_full,
    output logic       push,
    output m2h_entry_t entry
);

    logic [4:0] seed_len;

    always_comb
    begin
        if (int'(string_length) > MAX_LEN)
        begin
            seed_len = 5'(MAX_LEN);
        end
        else
        begin
            seed_len = string_length;
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // A first request of an empty string only seeds the hash; its byte is dropped.
    always_comb
    begin
        entry.data     = fold_case(byte_value);
        entry.seed_len = seed_len;
        entry.is_first = first_item;
        entry.is_last  = last_item;
        entry.take_en  = !(first_item && (seed_len == 5'd0));
    end

endmodule

// ===== src/m2h_queue.sv =====
`include "lowercase_murmur2_token_hash_macros.svh"

module m2h_queue
    import m2h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  m2h_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output m2h_entry_t pop_entry
);

    localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW   = $clog2(QDEPTH + 1);

    m2h_entry_t      mem [QDEPTH];
    logic [PTRW-1:0] wr_reg;
    logic [PTRW-1:0] wr_next;
    logic [PTRW-1:0] rd_reg;
    logic [PTRW-1:0] rd_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(QDEPTH));
    assign empty     = (count_reg == CW'(0));
    assign pop_entry = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTRW'(QDEPTH - 1)) ? PTRW'(0) : wr_reg + PTRW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTRW'(QDEPTH - 1)) ? PTRW'(0) : rd_reg + PTRW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `M2H_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(QDEPTH), "queue count beyond depth")
    `M2H_ASSERT_SAME(a_pop_nonempty, pop, count_reg != CW'(0), "pop from an empty queue")
    `M2H_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + CW'(1),
        "queue count did not grow on push")

endmodule

// ===== src/m2h_back.sv =====
`include "lowercase_murmur2_token_hash_macros.svh"

module m2h_back
    import m2h_pkg::*;
#(
    parameter int MAX_LEN = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] seed,
    input  logic        q_empty,
    input  m2h_entry_t  entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    localparam int             PW      = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0]  POS_MAX = PW'(MAX_LEN);

    m2h_state_t    state_reg;
    m2h_state_t    state_next;
    logic [31:0]   h_reg;
    logic [31:0]   h_next;
    logic [31:0]   k_reg;
    logic [31:0]   k_next;
    logic [23:0]   partial_reg;
    logic [23:0]   partial_next;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          last_reg;
    logic          last_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   hash_reg;
    logic [31:0]   hash_next;

    logic [31:0]   h_base;
    logic [23:0]   partial_base;
    logic [PW-1:0] pos_base;
    logic          take;
    logic [1:0]    lane;
    logic          word_done;
    logic [23:0]   partial_upd;
    logic [PW-1:0] pos_upd;
    logic          slot_free;
    logic [31:0]   mul_in;
    logic [31:0]   mul_p;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign mul_p      = mul_in * MUR_M;

    always_comb
    begin
        h_base       = entry.is_first ? (seed ^ {27'd0, entry.seed_len}) : h_reg;
        partial_base = entry.is_first ? 24'd0 : partial_reg;
        pos_base     = entry.is_first ? PW'(0) : pos_reg;
        take         = entry.take_en && (pos_base < POS_MAX);
        lane         = pos_base[1:0];
        word_done    = take && (lane == 2'd3);
        partial_upd  = partial_base;
        if (take)
        begin
            case (lane)
                2'd0:    partial_upd[7:0]   = entry.data;
                2'd1:    partial_upd[15:8]  = entry.data;
                2'd2:    partial_upd[23:16] = entry.data;
                default: partial_upd        = partial_base;
            endcase
        end
        pos_upd = take ? pos_base + PW'(1) : pos_base;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (word_done)
                    begin
                        state_next = ST_K1;
                    end
                    else if (entry.is_last)
                    begin
                        state_next = (pos_upd[1:0] != 2'd0) ? ST_FIN_TAIL : ST_FIN_AVAL;
                    end
                end
            end
            ST_K1:       state_next = ST_K2;
            ST_K2:       state_next = ST_MIXH;
            ST_MIXH:     state_next = last_reg ? ST_FIN_AVAL : ST_IDLE;
            ST_FIN_TAIL: state_next = ST_FIN_AVAL;
            ST_FIN_AVAL: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        mul_in         = h_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        partial_next   = partial_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        hash_next      = hash_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop          = 1'b1;
                    h_next       = h_base;
                    partial_next = word_done ? 24'd0 : partial_upd;
                    pos_next     = pos_upd;
                    last_next    = entry.is_last;
                    k_next       = {entry.data, partial_base};
                end
            end
            ST_K1:
            begin
                mul_in = k_reg;
                k_next = mul_p;
            end
            ST_K2:
            begin
                mul_in = k_reg ^ (k_reg >> KSHIFT);
                k_next = mul_p;
            end
            ST_MIXH:
            begin
                mul_in = h_reg;
                h_next = mul_p ^ k_reg;
            end
            ST_FIN_TAIL:
            begin
                mul_in = h_reg ^ {8'd0, partial_reg};
                h_next = mul_p;
            end
            ST_FIN_AVAL:
            begin
                mul_in = h_reg ^ (h_reg >> FSHIFT_A);
                h_next = mul_p;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    hash_next      = h_reg ^ (h_reg >> FSHIFT_B);
                    out_valid_next = 1'b1;
                    h_next         = 32'd0;
                    partial_next   = 24'd0;
                    pos_next       = PW'(0);
                end
            end
            default:
            begin
                mul_in = h_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        hash_reg <= hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= 32'd0;
            partial_reg   <= 24'd0;
            pos_reg       <= PW'(0);
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            partial_reg   <= partial_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `M2H_ASSERT_SAME(a_pos_bound, 1'b1, pos_reg <= POS_MAX, "byte position passed the limit")
    `M2H_ASSERT_SAME(a_word_aligned, state_reg == ST_MIXH, pos_reg[1:0] == 2'd0,
        "word mix with a misaligned byte position")
    `M2H_ASSERT_SAME(a_tail_present, state_reg == ST_FIN_TAIL, pos_reg[1:0] != 2'd0,
        "tail mix without tail bytes")
    `M2H_ASSERT_NEXT(a_emit_loads, (state_reg == ST_EMIT) && slot_free, out_valid_reg,
        "finished hash was not loaded into the output register")

endmodule

// ===== src/lowercase_murmur2_token_hash.sv =====
// Throughput: one byte request per cycle while the queue has room; a byte that completes a
// 4-byte word holds the back end while one shared 32x32 multiplier runs three times, and a
// last request holds it through the finish. A last request passes the queue hop, an optional
// word mix or tail mix, and the avalanche, and waits in ST_EMIT while the output is stalled.
// Reset is asynchronous and active low; it empties the queue, clears the running hash state
// and the output valid, and sets the seed register to 0x31415926.
module lowercase_murmur2_token_hash
    import m2h_pkg::*;
#(
    parameter int MAX_LEN = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic [4:0]  string_length,
    input  logic        first_item,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic        push;
    logic        q_full;
    logic        q_empty;
    logic        pop;
    m2h_entry_t  push_entry;
    m2h_entry_t  pop_entry;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    m2h_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_value    (byte_value),
        .string_length (string_length),
        .first_item    (first_item),
        .last_item     (last_item),
        .q_full        (q_full),
        .push          (push),
        .entry         (push_entry)
    );

    m2h_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .pop_entry  (pop_entry)
    );

    m2h_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (seed_reg),
        .q_empty    (q_empty),
        .entry      (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import m2h_pkg::*;
();

    localparam int MAX_BYTES    = 31;
    localparam int DRAIN_CYCLES = 16;
    localparam int TOTAL_ITEMS  = 1450;
    localparam int NUM_PHASES   = 5;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        bit          set_seed;
        logic [31:0] seed;
        logic [7:0]  b;
        logic [4:0]  len;
        bit          first_flag;
        bit          last_flag;
        bit          has_gold;
        logic [31:0] gold;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_value;
    logic [4:0]  string_length;
    logic        first_item;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] hash_value;

    logic [31:0] seed_reg;
    logic [31:0] run_hash;
    logic [23:0] part_word;
    logic [4:0]  byte_pos;
    bit          byte_taken;

    logic [31:0] pending_hashes[$];
    dir_row_t    dir_rows[$];

    int mismatches;
    int unexpected;
    int hashes_checked;
    int requests_sent;
    int items_done;
    int strings_sent;
    int seed_writes;
    bit sender_burst;
    bit hold_request;

    lowercase_murmur2_token_hash #(
        .MAX_LEN(MAX_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .byte_value(byte_value),
        .string_length(string_length),
        .first_item(first_item),
        .last_item(last_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hash_value(hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit murmur_step(input logic [7:0] b, input logic [4:0] len,
                                       input bit first_flag, input bit last_flag,
                                       output logic [31:0] hash_out);
        logic [4:0]  seed_len;
        logic [7:0]  lc;
        logic [31:0] k;
        logic [31:0] h;
        bit          skip;
        begin
            skip = 1'b0;
            hash_out = '0;
            byte_taken = 1'b0;
            if (first_flag)
            begin
                seed_len = (len > MAX_BYTES) ? MAX_BYTES[4:0] : len;
                run_hash = seed_reg ^ {27'd0, seed_len};
                part_word = '0;
                byte_pos = '0;
                skip = (seed_len == 5'd0);
            end
            if (!skip && byte_pos < MAX_BYTES)
            begin
                lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
                if (byte_pos[1:0] == 2'd3)
                begin
                    k = {lc, part_word};
                    k = k * MUR_M;
                    k = k ^ (k >> KSHIFT);
                    k = k * MUR_M;
                    run_hash = (run_hash * MUR_M) ^ k;
                    part_word = '0;
                end
                else
                begin
                    part_word = part_word | ({16'd0, lc} << (8 * byte_pos[1:0]));
                end
                byte_pos = byte_pos + 5'd1;
                byte_taken = 1'b1;
            end
            if (last_flag)
            begin
                h = run_hash;
                if (byte_pos[1:0] != 2'd0)
                begin
                    h = h ^ {8'd0, part_word};
                    h = h * MUR_M;
                end
                h = h ^ (h >> FSHIFT_A);
                h = h * MUR_M;
                h = h ^ (h >> FSHIFT_B);
                hash_out = h;
                run_hash = '0;
                part_word = '0;
                byte_pos = '0;
            end
            return last_flag;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (sender_burst || r < 60)
            begin
                return 0;
            end
            else if (r < 90)
            begin
                return $urandom_range(1, 3);
            end
            else if (r < 98)
            begin
                return $urandom_range(4, 10);
            end
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                return 8'h41 + 8'($urandom_range(0, 25));
            end
            else if (r < 6)
            begin
                return 8'h61 + 8'($urandom_range(0, 25));
            end
            else if (r == 6)
            begin
                return ($urandom_range(0, 1) != 0) ? 8'h40 : 8'h5B;
            end
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic send_request(input logic [7:0] b, input logic [4:0] len,
                                input bit first_flag, input bit last_flag,
                                input bit has_gold, input logic [31:0] gold);
        int          gap;
        logic [31:0] predicted;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid      <= 1'b1;
            byte_value    <= b;
            string_length <= len;
            first_item    <= first_flag;
            last_item     <= last_flag;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            requests_sent++;
            if (murmur_step(b, len, first_flag, last_flag, predicted))
            begin
                pending_hashes.push_back(has_gold ? gold : predicted);
            end
            if (byte_taken || last_flag)
            begin
                items_done++;
            end
        end
    endtask

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_hashes.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic load_seed(input logic [31:0] value);
        begin
            wait_drained();
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
            seed_reg = value;
            seed_writes++;
        end
    endtask

    task automatic add_row(input bit set_seed, input logic [31:0] seed, input logic [7:0] b,
                           input logic [4:0] len, input bit first_flag, input bit last_flag,
                           input bit has_gold, input logic [31:0] gold);
        dir_row_t row;
        begin
            row.set_seed   = set_seed;
            row.seed       = seed;
            row.b          = b;
            row.len        = len;
            row.first_flag = first_flag;
            row.last_flag  = last_flag;
            row.has_gold   = has_gold;
            row.gold       = gold;
            dir_rows.push_back(row);
        end
    endtask

    task automatic send_random_string();
        int kind;
        int n;
        int decl;
        int i;
        bit f;
        bit l;
        begin
            kind = $urandom_range(0, 99);
            strings_sent++;
            if (kind < 90)
            begin
                if (kind < 75)
                begin
                    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, MAX_BYTES);
                    decl = n;
                end
                else if (kind < 83)
                begin
                    n = $urandom_range(1, MAX_BYTES);
                    decl = $urandom_range(0, MAX_BYTES);
                end
                else
                begin
                    n = $urandom_range(MAX_BYTES + 1, 40);
                    decl = ($urandom_range(0, 1) != 0) ? MAX_BYTES : $urandom_range(0, MAX_BYTES);
                end
                if (n == 0)
                begin
                    send_request(8'($urandom_range(0, 255)), 5'd0, 1'b1, 1'b1, 1'b0, '0);
                end
                for (i = 0; i < n; i++)
                begin
                    send_request(pick_char(), (i == 0) ? decl[4:0] : 5'($urandom_range(0, 31)),
                                 i == 0, i == n - 1, 1'b0, '0);
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                begin
                    f = ($urandom_range(0, 3) == 0);
                    l = ($urandom_range(0, 3) == 0);
                    send_request(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), f, l,
                                 1'b0, '0);
                end
            end
        end
    endtask

    initial
    begin
        int stall_left;
        int free_left;
        int r;
        logic [31:0] want;
        stall_left = 0;
        free_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_hashes.size() == 0)
                begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                    begin
                        $display("hash %h delivered with no pending request", hash_value);
                    end
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    hashes_checked++;
                    if (hash_value !== want)
                    begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                        begin
                            $display("hash mismatch: expected %h, got %h", want, hash_value);
                        end
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
                free_left = 0;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    free_left = $urandom_range(1, 8);
                end
                else if (r < 60)
                begin
                    free_left = $urandom_range(30, 80);
                end
                else if (r < 95)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else
                begin
                    stall_left = $urandom_range(10, 40);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                free_left--;
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [31:0] phase_seeds[NUM_PHASES];
        int p;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        byte_value = '0;
        string_length = '0;
        first_item = 1'b0;
        last_item = 1'b0;
        seed_reg = SEED_RESET;
        run_hash = '0;
        part_word = '0;
        byte_pos = '0;
        sender_burst = 1'b0;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(1'b0, '0, 8'hFF, 5'd0, 1'b1, 1'b1, 1'b0, '0);
        add_row(1'b0, '0, 8'h41, 5'd4, 1'b1, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h40, 5'd4, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h5B, 5'd4, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h5A, 5'd4, 1'b0, 1'b1, 1'b0, '0);
        add_row(1'b0, '0, 8'h7A, 5'd3, 1'b1, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h00, 5'd3, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'hFF, 5'd3, 1'b0, 1'b1, 1'b0, '0);
        add_row(1'b1, 32'h0000_0000, 8'h5A, 5'd0, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
        add_row(1'b1, 32'h0000_0001, 8'h00, 5'd1, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
        add_row(1'b1, 32'hFFFF_FFFF, 8'hFF, 5'd31, 1'b1, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h41, 5'd31, 1'b0, 1'b1, 1'b0, '0);
        add_row(1'b0, '0, 8'h61, 5'd0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h62, 5'd0, 1'b0, 1'b1, 1'b0, '0);
        add_row(1'b0, '0, 8'h11, 5'd2, 1'b1, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h22, 5'd1, 1'b1, 1'b1, 1'b0, '0);
        add_row(1'b0, '0, 8'h33, 5'd0, 1'b1, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h44, 5'd9, 1'b0, 1'b1, 1'b0, '0);
        add_row(1'b1, SEED_RESET, 8'h51, 5'd2, 1'b1, 1'b0, 1'b0, '0);
        add_row(1'b0, '0, 8'h71, 5'd2, 1'b0, 1'b1, 1'b0, '0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_seed)
            begin
                load_seed(dir_rows[i].seed);
            end
            send_request(dir_rows[i].b, dir_rows[i].len, dir_rows[i].first_flag,
                         dir_rows[i].last_flag, dir_rows[i].has_gold, dir_rows[i].gold);
        end

        phase_seeds[0] = $urandom;
        phase_seeds[1] = 32'h0000_0000;
        phase_seeds[2] = 32'hFFFF_FFFF;
        phase_seeds[3] = $urandom;
        phase_seeds[4] = SEED_RESET;
        items_done = 0;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            load_seed(phase_seeds[p]);
            if (p == 1)
            begin
                hold_request = 1'b1;
                sender_burst = 1'b1;
            end
            while (items_done < (p + 1) * TOTAL_ITEMS / NUM_PHASES)
            begin
                if (p == 1 && items_done > (p * TOTAL_ITEMS / NUM_PHASES) + 120)
                begin
                    sender_burst = 1'b0;
                end
                if (p == 2 && items_done == (p * TOTAL_ITEMS / NUM_PHASES) + 100)
                begin
                    wait_drained();
                end
                send_random_string();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d strings as %0d byte requests under %0d seed settings.",
                 strings_sent, requests_sent, seed_writes);
        $display("Checked %0d hashes, including long output hold-off and drained pauses.",
                 hashes_checked);
        if (mismatches == 0 && unexpected == 0 && pending_hashes.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
